// File: hw/rtl/dapt_pkg.sv
// Shared types, widths and constants for the dual-axis PID tilt controller.
package dapt_pkg;

    localparam int TILT_W     = 16;
    localparam int CENT_W     = 16;
    localparam int GAIN_W     = 16;
    localparam int MAXT_W     = 7;
    localparam int LIMIT_W    = 12;
    localparam int ERR_W      = 17;
    localparam int SUM_W      = 21;
    localparam int SUMX_W     = 22;
    localparam int DIFF_W     = 18;
    localparam int OPA_W      = 21;
    localparam int PROD_W     = 38;
    localparam int ACC_W      = 39;
    localparam int TGT_SHIFT  = 7;
    localparam int TGT_W      = 16;
    localparam int EFF_SHIFT  = 15;
    localparam int EFF_W      = ACC_W - EFF_SHIFT;
    localparam int DEG_SHIFT  = 7;
    localparam int DUTY_W     = 8;
    localparam int DRIVE_W    = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [DUTY_W-1:0] DUTY_MAX = 8'd255;

    localparam logic [GAIN_W-1:0]  GAIN_P_RST    = 16'd10240;
    localparam logic [GAIN_W-1:0]  GAIN_I_RST    = 16'd26;
    localparam logic [GAIN_W-1:0]  GAIN_D_RST    = 16'd2560;
    localparam logic [MAXT_W-1:0]  MAX_TILT_RST  = 7'd10;
    localparam logic [LIMIT_W-1:0] SUM_LIMIT_RST = 12'd2550;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P    = 3'd0,
        CFG_GAIN_I    = 3'd1,
        CFG_GAIN_D    = 3'd2,
        CFG_MAX_TILT  = 3'd3,
        CFG_SUM_LIMIT = 3'd4
    } cfg_index_t;

    typedef enum logic [DRIVE_W-1:0] {
        DRIVE_BRAKE = 2'd0,
        DRIVE_FWD   = 2'd1,
        DRIVE_REV   = 2'd2
    } drive_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TGT,
        ST_ERR,
        ST_MP,
        ST_MI,
        ST_MD,
        ST_ACC,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic mul_en;
        logic acc_load;
        logic acc_add;
    } mac_ctrl_t;

endpackage

// File: hw/rtl/dual_axis_pid_tilt_controller_core.sv
// Top level of the dual-axis PID tilt controller with clamped integral.
//
//  channel   direction  handshake          payload
//  s_*       in         s_valid/s_ready    tilt_x, tilt_y, centroid_x, centroid_y
//  m_*       out        m_valid/m_ready    duty_x, drive_x, duty_y, drive_y
//  cfg_*     in         cfg_wr_en          cfg_index, cfg_data
//
// Each item passes through seven steps per axis on the single shared multiplier
// (target, error/clamp, three gain products, accumulate, duty/drive) before m_valid.
// s_ready is high only while idle, so no new beat is taken until the last one is done.
// aresetn (synchronous, active low) clears the sums and previous errors and
// restores the register defaults.
// A waiting result holds the block at its last step until m_ready takes it.
module dual_axis_pid_tilt_controller_core import dapt_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [TILT_W-1:0]  s_tilt_x,
    input  logic signed [TILT_W-1:0]  s_tilt_y,
    input  logic signed [CENT_W-1:0]  s_centroid_x,
    input  logic signed [CENT_W-1:0]  s_centroid_y,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [DUTY_W-1:0]         m_duty_x,
    output logic [DRIVE_W-1:0]        m_drive_x,
    output logic [DUTY_W-1:0]         m_duty_y,
    output logic [DRIVE_W-1:0]        m_drive_y,
    input  logic                      cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data
);

    state_t state_reg, state_next;
    logic   axis_reg;

    logic [GAIN_W-1:0]  gain_p_reg, gain_i_reg, gain_d_reg;
    logic [MAXT_W-1:0]  max_tilt_reg;
    logic [LIMIT_W-1:0] sum_limit_reg;

    logic signed [TILT_W-1:0] tilt_x_reg, tilt_y_reg;
    logic signed [CENT_W-1:0] cent_x_reg, cent_y_reg;

    logic signed [SUM_W-1:0]  sum_x_reg, sum_y_reg;
    logic signed [ERR_W-1:0]  prev_x_reg, prev_y_reg;

    logic signed [ERR_W-1:0]  err_reg;
    logic signed [SUM_W-1:0]  cur_sum_reg;
    logic signed [DIFF_W-1:0] diff_reg;

    logic [DUTY_W-1:0]  hold_duty_reg;
    logic [DRIVE_W-1:0] hold_drive_reg;

    logic               m_valid_reg;
    logic [DUTY_W-1:0]  duty_x_reg, duty_y_reg;
    logic [DRIVE_W-1:0] drive_x_reg, drive_y_reg;

    mac_ctrl_t                mac_ctrl;
    logic signed [OPA_W-1:0]  op_a;
    logic        [GAIN_W-1:0] op_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  acc;

    logic accept;
    logic fin_go;

    // error step
    logic signed [TILT_W-1:0] tilt_sel;
    logic signed [CENT_W-1:0] cent_sel;
    logic signed [SUM_W-1:0]  sum_sel;
    logic signed [ERR_W-1:0]  prev_sel;
    logic signed [TGT_W-1:0]  target;
    logic signed [ERR_W-1:0]  err_now;
    logic signed [SUMX_W-1:0] sum_raw;
    logic signed [SUMX_W-1:0] lim_pos;
    logic signed [SUMX_W-1:0] lim_neg;
    logic signed [SUMX_W-1:0] sum_clamped;
    logic signed [DIFF_W-1:0] diff_now;

    // final step
    logic signed [EFF_W-1:0] eff;
    logic signed [EFF_W-1:0] eff_neg;
    logic                    eff_is_neg;
    logic                    eff_zero;
    logic                    sat;
    logic [DUTY_W-1:0]       duty_now;
    drive_t                  drive_now;

    dapt_mac u_mac (
        .aclk (aclk),
        .ctrl (mac_ctrl),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod),
        .acc  (acc)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign fin_go  = (state_reg == ST_FIN) && (!axis_reg || !m_valid_reg || m_ready);

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_p_reg    <= GAIN_P_RST;
            gain_i_reg    <= GAIN_I_RST;
            gain_d_reg    <= GAIN_D_RST;
            max_tilt_reg  <= MAX_TILT_RST;
            sum_limit_reg <= SUM_LIMIT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_GAIN_P:    gain_p_reg    <= cfg_data;
                CFG_GAIN_I:    gain_i_reg    <= cfg_data;
                CFG_GAIN_D:    gain_d_reg    <= cfg_data;
                CFG_MAX_TILT:  max_tilt_reg  <= cfg_data[MAXT_W-1:0];
                CFG_SUM_LIMIT: sum_limit_reg <= cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_TGT;
            end
            ST_TGT: state_next = ST_ERR;
            ST_ERR: state_next = ST_MP;
            ST_MP:  state_next = ST_MI;
            ST_MI:  state_next = ST_MD;
            ST_MD:  state_next = ST_ACC;
            ST_ACC: state_next = ST_FIN;
            ST_FIN: begin
                if (!axis_reg) begin
                    state_next = ST_TGT;
                end else if (fin_go) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // unit control and operand selection
    always_comb begin
        mac_ctrl = '0;
        op_a     = '0;
        op_b     = '0;
        case (state_reg)
            ST_TGT: begin
                mac_ctrl.mul_en = 1'b1;
                op_a = OPA_W'(cent_sel);
                op_b = GAIN_W'(max_tilt_reg);
            end
            ST_MP: begin
                mac_ctrl.mul_en = 1'b1;
                op_a = OPA_W'(err_reg);
                op_b = gain_p_reg;
            end
            ST_MI: begin
                mac_ctrl.mul_en   = 1'b1;
                mac_ctrl.acc_load = 1'b1;
                op_a = cur_sum_reg;
                op_b = gain_i_reg;
            end
            ST_MD: begin
                mac_ctrl.mul_en  = 1'b1;
                mac_ctrl.acc_add = 1'b1;
                op_a = OPA_W'(diff_reg);
                op_b = gain_d_reg;
            end
            ST_ACC: begin
                mac_ctrl.acc_add = 1'b1;
            end
            default: ;
        endcase
    end

    // error, clamped sum and difference
    always_comb begin
        tilt_sel = axis_reg ? tilt_y_reg : tilt_x_reg;
        cent_sel = axis_reg ? cent_y_reg : cent_x_reg;
        sum_sel  = axis_reg ? sum_y_reg  : sum_x_reg;
        prev_sel = axis_reg ? prev_y_reg : prev_x_reg;
        // product fits 23 bits; the arithmetic shift floors
        target   = prod[TGT_SHIFT+TGT_W-1:TGT_SHIFT];
        err_now  = ERR_W'(target) - ERR_W'(tilt_sel);
        sum_raw  = SUMX_W'(sum_sel) + SUMX_W'(err_now);
        lim_pos  = $signed({{(SUMX_W-LIMIT_W-DEG_SHIFT){1'b0}}, sum_limit_reg,
                            {DEG_SHIFT{1'b0}}});
        lim_neg  = -lim_pos;
        if (sum_raw > lim_pos) begin
            sum_clamped = lim_pos;
        end else if (sum_raw < lim_neg) begin
            sum_clamped = lim_neg;
        end else begin
            sum_clamped = sum_raw;
        end
        diff_now = DIFF_W'(err_now) - DIFF_W'(prev_sel);
    end

    // shifted effort to duty and drive code
    always_comb begin
        eff        = acc[ACC_W-1:EFF_SHIFT];
        eff_is_neg = eff[EFF_W-1];
        eff_zero   = (eff == '0);
        eff_neg    = -eff;
        if (eff_is_neg) begin
            sat      = (eff_neg[EFF_W-1:DUTY_W] != '0);
            duty_now = sat ? DUTY_MAX : eff_neg[DUTY_W-1:0];
        end else begin
            sat      = (eff[EFF_W-1:DUTY_W] != '0);
            duty_now = sat ? DUTY_MAX : eff[DUTY_W-1:0];
        end
        // Y drives the other way round
        if (eff_zero) begin
            drive_now = DRIVE_BRAKE;
        end else if (eff_is_neg == axis_reg) begin
            drive_now = DRIVE_FWD;
        end else begin
            drive_now = DRIVE_REV;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            axis_reg    <= 1'b0;
            sum_x_reg   <= '0;
            sum_y_reg   <= '0;
            prev_x_reg  <= '0;
            prev_y_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                axis_reg <= 1'b0;
            end else if (state_reg == ST_FIN && !axis_reg) begin
                axis_reg <= 1'b1;
            end
            if (state_reg == ST_ERR) begin
                if (axis_reg) begin
                    sum_y_reg  <= SUM_W'(sum_clamped);
                    prev_y_reg <= err_now;
                end else begin
                    sum_x_reg  <= SUM_W'(sum_clamped);
                    prev_x_reg <= err_now;
                end
            end
            if (fin_go && axis_reg) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload, step and result registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            tilt_x_reg <= s_tilt_x;
            tilt_y_reg <= s_tilt_y;
            cent_x_reg <= s_centroid_x;
            cent_y_reg <= s_centroid_y;
        end
        if (state_reg == ST_ERR) begin
            err_reg     <= err_now;
            cur_sum_reg <= SUM_W'(sum_clamped);
            diff_reg    <= diff_now;
        end
        if (state_reg == ST_FIN && !axis_reg) begin
            hold_duty_reg  <= duty_now;
            hold_drive_reg <= drive_now;
        end
        if (fin_go && axis_reg) begin
            duty_x_reg  <= hold_duty_reg;
            drive_x_reg <= hold_drive_reg;
            duty_y_reg  <= duty_now;
            drive_y_reg <= drive_now;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_duty_x  = duty_x_reg;
    assign m_drive_x = drive_x_reg;
    assign m_duty_y  = duty_y_reg;
    assign m_drive_y = drive_y_reg;

endmodule

// File: hw/rtl/dapt_mac.sv
// Shared multiply-accumulate unit: registered product, registered accumulator.
module dapt_mac import dapt_pkg::*; (
    input  logic                     aclk,
    input  mac_ctrl_t                ctrl,
    input  logic signed [OPA_W-1:0]  op_a,
    input  logic        [GAIN_W-1:0] op_b,
    output logic signed [PROD_W-1:0] prod,
    output logic signed [ACC_W-1:0]  acc
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  prod_ext;

    assign prod_ext = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            prod_reg <= op_a * $signed({1'b0, op_b});
        end
        if (ctrl.acc_load) begin
            acc_reg <= prod_ext;
        end else if (ctrl.acc_add) begin
            acc_reg <= acc_reg + prod_ext;
        end
    end

    assign prod = prod_reg;
    assign acc  = acc_reg;

endmodule

// File: tb/tb_dual_axis_pid_tilt_controller_core.sv
// Self-checking testbench for the dual-axis PID tilt controller core.
`timescale 1ns / 100ps

module tb_dual_axis_pid_tilt_controller_core;
    import dapt_pkg::*;

    typedef struct {
        logic [DUTY_W-1:0] duty_x;
        drive_t            drive_x;
        logic [DUTY_W-1:0] duty_y;
        drive_t            drive_y;
    } motor_cmd_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic signed [TILT_W-1:0] s_tilt_x = '0;
    logic signed [TILT_W-1:0] s_tilt_y = '0;
    logic signed [CENT_W-1:0] s_centroid_x = '0;
    logic signed [CENT_W-1:0] s_centroid_y = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic [DUTY_W-1:0]        m_duty_x;
    logic [DRIVE_W-1:0]       m_drive_x;
    logic [DUTY_W-1:0]        m_duty_y;
    logic [DRIVE_W-1:0]       m_drive_y;
    logic                     cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [CFG_DATA_W-1:0]    cfg_data = '0;

    // predictor copy of the registers and loop state
    logic [GAIN_W-1:0]        kp_q, ki_q, kd_q;
    logic [MAXT_W-1:0]        max_tilt_q;
    logic [LIMIT_W-1:0]       sum_limit_q;
    logic signed [SUM_W-1:0]  integ_x, integ_y;
    logic signed [ERR_W-1:0]  last_err_x, last_err_y;

    motor_cmd_t pending_cmds[$];
    int  mismatch_count = 0;
    int  results_seen = 0;
    bit  tx_free = 1'b0;
    bit  rx_free = 1'b0;
    int  rx_hold = 0;
    int  rx_gap = 0;

    // random walk state for well-formed tracking sequences
    int  walk_tx, walk_ty, walk_cx, walk_cy;
    int  walk_left = 0;

    dual_axis_pid_tilt_controller_core DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_tilt_x     (s_tilt_x),
        .s_tilt_y     (s_tilt_y),
        .s_centroid_x (s_centroid_x),
        .s_centroid_y (s_centroid_y),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_duty_x     (m_duty_x),
        .m_drive_x    (m_drive_x),
        .m_duty_y     (m_duty_y),
        .m_drive_y    (m_drive_y),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    initial begin
        #(20_000_000);
        $display("dual_axis_pid_tilt_controller_core verification failed");
        $finish;
    end

    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 15);
        return $urandom_range(16, 60);
    endfunction

    function automatic logic signed [15:0] pick_span(int lo, int hi);
        return 16'(lo + int'($urandom_range(0, hi - lo)));
    endfunction

    task automatic reset_model();
        kp_q        = GAIN_P_RST;
        ki_q        = GAIN_I_RST;
        kd_q        = GAIN_D_RST;
        max_tilt_q  = MAX_TILT_RST;
        sum_limit_q = SUM_LIMIT_RST;
        integ_x     = '0;
        integ_y     = '0;
        last_err_x  = '0;
        last_err_y  = '0;
    endtask

    function automatic void pid_axis(input logic signed [TILT_W-1:0] tilt,
                                     input logic signed [CENT_W-1:0] cent,
                                     input bit invert,
                                     inout logic signed [SUM_W-1:0] integ,
                                     inout logic signed [ERR_W-1:0] last_err,
                                     output logic [DUTY_W-1:0] duty,
                                     output drive_t drv);
        longint target, err, lim, s, raw, eff, mag;
        target = (longint'(cent) * longint'(max_tilt_q)) >>> TGT_SHIFT;
        err    = target - longint'(tilt);
        lim    = longint'(sum_limit_q) << DEG_SHIFT;
        s      = longint'(integ) + err;
        if (s > lim)  s = lim;
        if (s < -lim) s = -lim;
        raw = longint'(kp_q) * err + longint'(ki_q) * s
            + longint'(kd_q) * (err - longint'(last_err));
        eff = raw >>> EFF_SHIFT;   // floor toward minus infinity
        integ    = s[SUM_W-1:0];
        last_err = err[ERR_W-1:0];
        mag  = (eff < 0) ? -eff : eff;
        if (mag > longint'(DUTY_MAX)) mag = DUTY_MAX;
        duty = mag[DUTY_W-1:0];
        if (eff == 0)
            drv = DRIVE_BRAKE;
        else if ((eff > 0) != invert)
            drv = DRIVE_FWD;
        else
            drv = DRIVE_REV;
    endfunction

    function automatic motor_cmd_t predict_motor_cmd(input logic signed [TILT_W-1:0] tx, ty,
                                                     input logic signed [CENT_W-1:0] cx, cy);
        motor_cmd_t cmd;
        pid_axis(tx, cx, 1'b0, integ_x, last_err_x, cmd.duty_x, cmd.drive_x);
        pid_axis(ty, cy, 1'b1, integ_y, last_err_y, cmd.duty_y, cmd.drive_y);
        return cmd;
    endfunction

    // offer one beat, hold it until taken, then maybe idle for a while
    task automatic send_beat(input logic signed [TILT_W-1:0] tx, ty,
                             input logic signed [CENT_W-1:0] cx, cy);
        int gap;
        s_valid      <= 1'b1;
        s_tilt_x     <= tx;
        s_tilt_y     <= ty;
        s_centroid_x <= cx;
        s_centroid_y <= cy;
        do @(posedge aclk); while (!s_ready);
        pending_cmds.push_back(predict_motor_cmd(tx, ty, cx, cy));
        gap = tx_free ? 0 : pause_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // registers only change once the block has drained and gone idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_cmds.size() != 0 || !s_ready);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        case (idx)
            CFG_GAIN_P:    kp_q        = data[GAIN_W-1:0];
            CFG_GAIN_I:    ki_q        = data[GAIN_W-1:0];
            CFG_GAIN_D:    kd_q        = data[GAIN_W-1:0];
            CFG_MAX_TILT:  max_tilt_q  = data[MAXT_W-1:0];
            CFG_SUM_LIMIT: sum_limit_q = data[LIMIT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic random_beat();
        int mode;
        mode = $urandom_range(0, 9);
        if (mode < 2) begin
            // raw noise: any 16-bit pattern
            send_beat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        end else if (mode < 3) begin
            send_beat(pick_span(-23040, 23040), pick_span(-23040, 23040),
                      pick_span(-16384, 16384), pick_span(-16384, 16384));
        end else begin
            if (walk_left == 0) begin
                walk_tx   = pick_span(-23040, 23040);
                walk_ty   = pick_span(-23040, 23040);
                walk_cx   = pick_span(-16384, 16384);
                walk_cy   = pick_span(-16384, 16384);
                walk_left = $urandom_range(5, 30);
            end
            walk_left--;
            walk_tx += int'($urandom_range(0, 400)) - 200;
            walk_ty += int'($urandom_range(0, 400)) - 200;
            if (walk_tx > 23040)  walk_tx = 23040;
            if (walk_tx < -23040) walk_tx = -23040;
            if (walk_ty > 23040)  walk_ty = 23040;
            if (walk_ty < -23040) walk_ty = -23040;
            send_beat(16'(walk_tx), 16'(walk_ty), 16'(walk_cx), 16'(walk_cy));
        end
    endtask

    function automatic logic [CFG_DATA_W-1:0] random_gain(input logic [GAIN_W-1:0] dflt);
        case ($urandom_range(0, 3))
            0:       return 16'($urandom_range(0, 511));
            1:       return 16'($urandom_range(0, 4095));
            2:       return 16'($urandom);
            default: return dflt;
        endcase
    endfunction

    task automatic randomise_settings();
        write_reg(CFG_GAIN_P, random_gain(GAIN_P_RST));
        write_reg(CFG_GAIN_I, random_gain(GAIN_I_RST));
        write_reg(CFG_GAIN_D, random_gain(GAIN_D_RST));
        write_reg(CFG_MAX_TILT, ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                           : 16'($urandom_range(0, 90)));
        case ($urandom_range(0, 3))
            0:       write_reg(CFG_SUM_LIMIT, 16'($urandom_range(0, 15)));
            1:       write_reg(CFG_SUM_LIMIT, 16'($urandom));
            default: write_reg(CFG_SUM_LIMIT, 16'($urandom_range(0, 4095)));
        endcase
    endtask

    // reset values; field extremes, brake and the floor-to-minus-one case
    task automatic test_directed_corners();
        send_beat(16'sd1, 16'sd1, 16'sd0, 16'sd0);
        send_beat(16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_beat(16'sd23040, -16'sd23040, 16'sd16384, -16'sd16384);
        send_beat(-16'sd23040, 16'sd23040, -16'sd16384, 16'sd16384);
        send_beat(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000);
        send_beat(16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
        send_beat(16'sd0, 16'sd0, 16'sd16384, 16'sd16384);
        send_beat(16'sd0, 16'sd0, -16'sd16384, -16'sd16384);
        // drive the sums hard one way, then back the other
        repeat (6) send_beat(16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000);
        repeat (6) send_beat(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF);
    endtask

    task automatic test_register_extremes();
        int k;
        write_reg(CFG_GAIN_P, '0);
        write_reg(CFG_GAIN_I, '0);
        write_reg(CFG_GAIN_D, '0);
        repeat (15) random_beat();

        write_reg(CFG_GAIN_P, '1);
        write_reg(CFG_GAIN_I, '1);
        write_reg(CFG_GAIN_D, '1);
        write_reg(CFG_MAX_TILT, '1);
        write_reg(CFG_SUM_LIMIT, '1);
        repeat (20) random_beat();

        // integral only, tight clamp so the held sum shows in the duty
        write_reg(CFG_GAIN_P, '0);
        write_reg(CFG_GAIN_D, '0);
        write_reg(CFG_GAIN_I, 16'd16384);
        write_reg(CFG_MAX_TILT, 16'd90);
        write_reg(CFG_SUM_LIMIT, 16'd1);
        repeat (20) random_beat();
        write_reg(CFG_SUM_LIMIT, '0);
        repeat (10) random_beat();

        write_reg(CFG_GAIN_P, GAIN_P_RST);
        write_reg(CFG_GAIN_I, GAIN_I_RST);
        write_reg(CFG_GAIN_D, GAIN_D_RST);
        write_reg(CFG_MAX_TILT, '0);
        write_reg(CFG_SUM_LIMIT, SUM_LIMIT_RST);
        repeat (10) random_beat();
        write_reg(CFG_MAX_TILT, MAX_TILT_RST);
        // writes to unmapped indexes must leave the settings alone
        for (k = int'(CFG_SUM_LIMIT) + 1; k < 2 ** CFG_IDX_W; k++)
            write_reg(CFG_IDX_W'(k), 16'($urandom));
        repeat (10) random_beat();
    endtask

    // receiver holds off while the sender keeps offering beats
    task automatic test_backpressure();
        tx_free = 1'b1;
        rx_hold = 300;
        repeat (10) random_beat();
        rx_free = 1'b1;
        repeat (40) random_beat();
        tx_free = 1'b0;
        rx_free = 1'b0;
    endtask

    task automatic test_random_traffic();
        int phase;
        for (phase = 0; phase < 7; phase++) begin
            randomise_settings();
            repeat (100) random_beat();
        end
    endtask

    initial begin : m_ready_drive
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (rx_hold > 0) begin
                m_ready <= 1'b0;
                rx_hold--;
            end else if (rx_gap > 0) begin
                m_ready <= 1'b0;
                rx_gap--;
            end else begin
                m_ready <= 1'b1;
                if (!rx_free && $urandom_range(0, 3) == 0) rx_gap = pause_len();
            end
            @(posedge aclk);
        end
    end

    always @(posedge aclk) begin : check_results
        motor_cmd_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_cmds.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected result beat %0d", $time, results_seen);
            end else begin
                want = pending_cmds.pop_front();
                if (m_duty_x !== want.duty_x || m_drive_x !== want.drive_x ||
                    m_duty_y !== want.duty_y || m_drive_y !== want.drive_y) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $write("%0t: beat %0d duty_x %0d/%0d drive_x %0d/%0d",
                               $time, results_seen, want.duty_x, m_duty_x,
                               want.drive_x, m_drive_x);
                        $display(" duty_y %0d/%0d drive_y %0d/%0d (exp/act)",
                                 want.duty_y, m_duty_y, want.drive_y, m_drive_y);
                    end
                end
            end
        end
    end

    initial begin
        reset_model();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_corners();
        test_register_extremes();
        test_backpressure();
        test_random_traffic();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_cmds.size() != 0);
        repeat (30) @(posedge aclk);
        if (mismatch_count == 0 && pending_cmds.size() == 0)
            $display("dual_axis_pid_tilt_controller_core verification clean");
        else
            $display("dual_axis_pid_tilt_controller_core verification failed");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/dapt_pkg.sv
hw/rtl/dapt_mac.sv
hw/rtl/dual_axis_pid_tilt_controller_core.sv
tb/tb_dual_axis_pid_tilt_controller_core.sv
